// File: src/fhc_pkg.sv
// Shared types and constants of the fibre hit clusterizer.
package fhc_pkg;

  localparam int FIBRE_W  = 10;
  localparam int CENTER_W = 18;
  localparam int COUNT_W  = 8;
  localparam int GAP_W    = 24;
  localparam int CFG_W    = 24;
  localparam int IDX_W    = 1;

  localparam logic [CENTER_W-1:0] CENTER_MAX = 18'h3FFFF;
  localparam logic [COUNT_W-1:0]  COUNT_MAX  = 8'hFF;

  // configuration register indexes
  localparam logic [IDX_W-1:0] CFG_ENABLE = 1'b0;
  localparam logic [IDX_W-1:0] CFG_GAP    = 1'b1;

  localparam logic             ENABLE_RST = 1'b1;
  localparam logic [GAP_W-1:0] GAP_RST    = 24'd80;

  // close-command queue
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  typedef struct packed {
    logic known;
    logic ovf;
    logic last;
  } fhc_flags_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_WRITE
  } fhc_state_e;

endpackage

// File: src/fhc_front.sv
// Front end: hit acceptance, cluster membership test and running sums.
module fhc_front #(
  parameter int NUM_FIBRES = 1024,
  parameter int MAX_HITS   = 255,
  parameter int TIME_BITS  = 24,
  parameter int CNT_W      = 8,
  parameter int FSUM_W     = 18,
  parameter int TSUM_W     = 32,
  parameter int ENT_W      = 61
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [fhc_pkg::IDX_W-1:0]     cfg_idx_i,
  input  logic [fhc_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [fhc_pkg::FIBRE_W-1:0]   fibre_i,
  input  logic signed [TIME_BITS-1:0]   hit_time_i,
  input  logic                          last_hit_i,
  input  logic                          q_room_i,
  output logic                          push_a_o,
  output logic                          push_b_o,
  output logic [ENT_W-1:0]              ent_a_o,
  output logic [ENT_W-1:0]              ent_b_o
);

  localparam int FW     = fhc_pkg::FIBRE_W;
  localparam int FMAX_I = (NUM_FIBRES > 1024) ? 1023 : NUM_FIBRES - 1;
  localparam logic [FW-1:0] FMAX = FW'(FMAX_I);
  localparam int TD_W   = TIME_BITS + 1;
  localparam int CMP_W  = (TD_W > fhc_pkg::GAP_W) ? TD_W : fhc_pkg::GAP_W;

  logic                        en_q;
  logic [fhc_pkg::GAP_W-1:0]   gap_q;
  logic [FSUM_W-1:0]           fsum_q, fsum_d;
  logic signed [TSUM_W-1:0]    tsum_q, tsum_d;
  logic [CNT_W-1:0]            cnt_q, cnt_d;
  logic [FW-1:0]               prev_f_q;
  logic [TIME_BITS-1:0]        prev_t_q;
  logic                        open_q, open_d;

  logic                        accept;
  logic [FW-1:0]               f_cl;
  logic                        df_big, gap_big, close1, close2, keep, ovf;
  logic signed [TD_W-1:0]      dt;
  logic [TD_W-1:0]             dt_mag;
  logic [TSUM_W-1:0]           t_ext;
  fhc_pkg::fhc_flags_t         fl1, fl2;
  logic [ENT_W-1:0]            e1, e2;

  assign in_ready_o = q_room_i;
  assign accept     = in_valid_i & in_ready_o;

  always_comb begin
    f_cl    = (fibre_i > FMAX) ? FMAX : fibre_i;
    t_ext   = {{CNT_W{hit_time_i[TIME_BITS-1]}}, hit_time_i};
    df_big  = {1'b0, f_cl} > ({1'b0, prev_f_q} + (FW + 1)'(1));
    dt      = {hit_time_i[TIME_BITS-1], hit_time_i} - {prev_t_q[TIME_BITS-1], prev_t_q};
    dt_mag  = dt[TD_W-1] ? -dt : dt;
    gap_big = CMP_W'(dt_mag) > CMP_W'(gap_q);
    close1  = open_q & (~en_q | df_big | gap_big);
    keep    = open_q & ~close1;

    fsum_d = (keep ? fsum_q : '0) + FSUM_W'(f_cl);
    tsum_d = (keep ? tsum_q : '0) + t_ext;
    cnt_d  = (keep ? cnt_q : '0) + CNT_W'(1);
    ovf    = cnt_d >= CNT_W'(MAX_HITS);

    // with clustering off every hit is reported on its own
    close2 = en_q ? (ovf | last_hit_i) : 1'b1;
    open_d = en_q & ~close2;

    fl1 = '{known: 1'b1, ovf: 1'b0, last: ~close2};
    fl2 = '{known: en_q, ovf: en_q & ovf, last: 1'b1};
    e1  = {fsum_q, tsum_q, cnt_q, fl1};
    if (en_q) begin
      e2 = {fsum_d, tsum_d, cnt_d, fl2};
    end else begin
      e2 = {FSUM_W'(f_cl), t_ext, CNT_W'(1), fl2};
    end

    push_a_o = accept & (close1 | close2);
    push_b_o = accept & close1 & close2;
    ent_a_o  = close1 ? e1 : e2;
    ent_b_o  = e2;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q     <= fhc_pkg::ENABLE_RST;
      gap_q    <= fhc_pkg::GAP_RST;
      fsum_q   <= '0;
      tsum_q   <= '0;
      cnt_q    <= '0;
      prev_f_q <= '0;
      prev_t_q <= '0;
      open_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          fhc_pkg::CFG_ENABLE: en_q  <= cfg_wdata_i[0];
          fhc_pkg::CFG_GAP:    gap_q <= cfg_wdata_i[fhc_pkg::GAP_W-1:0];
          default: ;
        endcase
      end
      if (accept) begin
        if (en_q) begin
          fsum_q <= fsum_d;
          tsum_q <= tsum_d;
          cnt_q  <= cnt_d;
        end
        open_q   <= open_d;
        prev_f_q <= f_cl;
        prev_t_q <= hit_time_i;
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) push_b_o |-> push_a_o)
    else $error("second close without a first");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && en_q && last_hit_i) |=> !open_q)
    else $error("cluster left open after last hit");

endmodule

// File: src/fhc_queue.sv
// Small FIFO of cluster close commands, up to two writes per cycle.
module fhc_queue #(
  parameter int ENT_W = 61
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_a_i,
  input  logic             push_b_i,
  input  logic [ENT_W-1:0] ent_a_i,
  input  logic [ENT_W-1:0] ent_b_i,
  input  logic             pop_i,
  output logic [ENT_W-1:0] head_o,
  output logic             empty_o,
  output logic             room_o
);

  localparam int PW = fhc_pkg::QPTR_W;
  localparam int CW = fhc_pkg::QCNT_W;

  logic [ENT_W-1:0] mem_q [fhc_pkg::QDEPTH];
  logic [PW-1:0]    wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [PW-1:0]    wptr_b;

  assign wptr_b  = wptr_q + PW'(1);
  assign head_o  = mem_q[rptr_q];
  assign empty_o = (cnt_q == '0);
  assign room_o  = (cnt_q <= CW'(fhc_pkg::QDEPTH - 2));

  always_comb begin
    wptr_d = wptr_q + PW'(push_a_i) + PW'(push_b_i);
    rptr_d = rptr_q + PW'(pop_i);
    cnt_d  = cnt_q + CW'(push_a_i) + CW'(push_b_i) - CW'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push_a_i) begin
      mem_q[wptr_q] <= ent_a_i;
    end
    if (push_b_i) begin
      mem_q[wptr_b] <= ent_b_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) pop_i |-> !empty_o)
    else $error("pop from empty queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_a_i || push_b_i) |-> (cnt_q <= CW'(fhc_pkg::QDEPTH - 2)))
    else $error("queue overflow");

endmodule

// File: src/fhc_back.sv
// Back end: bit-serial mean division and the result register.
module fhc_back #(
  parameter int TIME_BITS = 24,
  parameter int CNT_W     = 8,
  parameter int FSUM_W    = 18,
  parameter int TSUM_W    = 32,
  parameter int ENT_W     = 61
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [ENT_W-1:0]                head_i,
  input  logic                            empty_i,
  output logic                            pop_o,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [fhc_pkg::CENTER_W-1:0]    center_fibre_o,
  output logic signed [TIME_BITS-1:0]     cluster_time_o,
  output logic [fhc_pkg::COUNT_W-1:0]     hit_count_o,
  output logic                            size_known_o,
  output logic                            size_overflow_o,
  output logic                            last_of_run_o
);

  localparam int FD_W  = FSUM_W + 8;
  localparam int DIV_W = (FD_W > TSUM_W) ? FD_W : TSUM_W;
  localparam int SC_W  = $clog2(DIV_W);
  localparam int CX_W  = (CNT_W > fhc_pkg::COUNT_W) ? CNT_W : fhc_pkg::COUNT_W;

  logic [FSUM_W-1:0]          e_fsum;
  logic signed [TSUM_W-1:0]   e_tsum;
  logic [CNT_W-1:0]           e_cnt;
  fhc_pkg::fhc_flags_t        e_flags;
  logic [TSUM_W-1:0]          e_tmag;

  fhc_pkg::fhc_state_e        state_q, state_d;
  logic [DIV_W-1:0]           fq_q, tq_q, fq_d, tq_d;
  logic [CNT_W-1:0]           frem_q, trem_q, frem_d, trem_d, div_q;
  logic [CNT_W:0]             fsh, tsh, fdiff, tdiff;
  logic                       fge, tge, neg_q;
  logic [SC_W-1:0]            step_q;
  fhc_pkg::fhc_flags_t        flags_q;
  logic                       out_free, out_valid_q, load;

  logic [fhc_pkg::CENTER_W-1:0] center_res;
  logic [TIME_BITS-1:0]         tmag;
  logic [TIME_BITS-1:0]         time_res;
  logic [CX_W-1:0]              cnt_x;
  logic [fhc_pkg::COUNT_W-1:0]  count_res;

  assign {e_fsum, e_tsum, e_cnt, e_flags} = head_i;
  assign e_tmag   = e_tsum[TSUM_W-1] ? -e_tsum : e_tsum;
  assign out_free = ~out_valid_q | out_ready_i;

  // one restoring step per cycle on both sums, shared divisor
  always_comb begin
    fsh    = {frem_q, fq_q[DIV_W-1]};
    tsh    = {trem_q, tq_q[DIV_W-1]};
    fge    = fsh >= {1'b0, div_q};
    tge    = tsh >= {1'b0, div_q};
    fdiff  = fsh - {1'b0, div_q};
    tdiff  = tsh - {1'b0, div_q};
    frem_d = fge ? fdiff[CNT_W-1:0] : fsh[CNT_W-1:0];
    trem_d = tge ? tdiff[CNT_W-1:0] : tsh[CNT_W-1:0];
    fq_d   = {fq_q[DIV_W-2:0], fge};
    tq_d   = {tq_q[DIV_W-2:0], tge};
  end

  always_comb begin
    state_d = state_q;
    pop_o   = 1'b0;
    load    = 1'b0;
    unique case (state_q)
      fhc_pkg::S_IDLE: begin
        if (!empty_i) begin
          pop_o   = 1'b1;
          load    = 1'b1;
          // a single hit needs no division
          state_d = (e_cnt == CNT_W'(1)) ? fhc_pkg::S_WRITE : fhc_pkg::S_DIV;
        end
      end
      fhc_pkg::S_DIV: begin
        if (step_q == '0) begin
          state_d = fhc_pkg::S_WRITE;
        end
      end
      fhc_pkg::S_WRITE: begin
        if (out_free) begin
          state_d = fhc_pkg::S_IDLE;
        end
      end
      default: state_d = fhc_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    center_res = (fq_q > DIV_W'(fhc_pkg::CENTER_MAX)) ? fhc_pkg::CENTER_MAX
                                                      : fq_q[fhc_pkg::CENTER_W-1:0];
    tmag       = tq_q[TIME_BITS-1:0];
    time_res   = neg_q ? -tmag : tmag;
    cnt_x      = CX_W'(div_q);
    count_res  = (cnt_x > CX_W'(fhc_pkg::COUNT_MAX)) ? fhc_pkg::COUNT_MAX
                                                     : cnt_x[fhc_pkg::COUNT_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fhc_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == fhc_pkg::S_WRITE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      fq_q    <= DIV_W'({e_fsum, 8'h00});
      tq_q    <= DIV_W'(e_tmag);
      frem_q  <= '0;
      trem_q  <= '0;
      div_q   <= e_cnt;
      neg_q   <= e_tsum[TSUM_W-1];
      flags_q <= e_flags;
      step_q  <= SC_W'(DIV_W - 1);
    end else if (state_q == fhc_pkg::S_DIV) begin
      fq_q   <= fq_d;
      tq_q   <= tq_d;
      frem_q <= frem_d;
      trem_q <= trem_d;
      step_q <= step_q - SC_W'(1);
    end
    if (state_q == fhc_pkg::S_WRITE && out_free) begin
      center_fibre_o  <= center_res;
      cluster_time_o  <= time_res;
      hit_count_o     <= count_res;
      size_known_o    <= flags_q.known;
      size_overflow_o <= flags_q.ovf;
      last_of_run_o   <= flags_q.last;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// File: src/fibre_hit_clusterizer.sv
// Path: a closing hit puts its cluster into the close queue; the back end pops it and,
//   unless it holds a single hit, divides bit-serially over DIV = max(sum-of-fibres
//   width + 8, TIME_BITS + count width) bits (32 by default), then registers the result.
// Throughput: one hit per cycle while the four-entry close queue has two free slots;
//   the back end takes one cluster at a time, popping the next after writing the last.
// Reset: asynchronous, active low; no cluster open, clustering on, gap 80.
module fibre_hit_clusterizer #(
  parameter int NUM_FIBRES = 1024,
  parameter int MAX_HITS   = 255,
  parameter int TIME_BITS  = 24
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [fhc_pkg::IDX_W-1:0]       cfg_idx_i,
  input  logic [fhc_pkg::CFG_W-1:0]       cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [fhc_pkg::FIBRE_W-1:0]     fibre_i,
  input  logic signed [TIME_BITS-1:0]     hit_time_i,
  input  logic                            last_hit_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [fhc_pkg::CENTER_W-1:0]    center_fibre_o,
  output logic signed [TIME_BITS-1:0]     cluster_time_o,
  output logic [fhc_pkg::COUNT_W-1:0]     hit_count_o,
  output logic                            size_known_o,
  output logic                            size_overflow_o,
  output logic                            last_of_run_o
);

  localparam int CNT_W  = $clog2(MAX_HITS + 1);
  localparam int FSUM_W = fhc_pkg::FIBRE_W + CNT_W;
  localparam int TSUM_W = TIME_BITS + CNT_W;
  localparam int ENT_W  = FSUM_W + TSUM_W + CNT_W + $bits(fhc_pkg::fhc_flags_t);

  logic             push_a, push_b, pop, q_empty, q_room;
  logic [ENT_W-1:0] ent_a, ent_b, head;

  fhc_front #(
    .NUM_FIBRES (NUM_FIBRES),
    .MAX_HITS   (MAX_HITS),
    .TIME_BITS  (TIME_BITS),
    .CNT_W      (CNT_W),
    .FSUM_W     (FSUM_W),
    .TSUM_W     (TSUM_W),
    .ENT_W      (ENT_W)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .fibre_i     (fibre_i),
    .hit_time_i  (hit_time_i),
    .last_hit_i  (last_hit_i),
    .q_room_i    (q_room),
    .push_a_o    (push_a),
    .push_b_o    (push_b),
    .ent_a_o     (ent_a),
    .ent_b_o     (ent_b)
  );

  fhc_queue #(
    .ENT_W (ENT_W)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_a_i (push_a),
    .push_b_i (push_b),
    .ent_a_i  (ent_a),
    .ent_b_i  (ent_b),
    .pop_i    (pop),
    .head_o   (head),
    .empty_o  (q_empty),
    .room_o   (q_room)
  );

  fhc_back #(
    .TIME_BITS (TIME_BITS),
    .CNT_W     (CNT_W),
    .FSUM_W    (FSUM_W),
    .TSUM_W    (TSUM_W),
    .ENT_W     (ENT_W)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .head_i          (head),
    .empty_i         (q_empty),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .center_fibre_o  (center_fibre_o),
    .cluster_time_o  (cluster_time_o),
    .hit_count_o     (hit_count_o),
    .size_known_o    (size_known_o),
    .size_overflow_o (size_overflow_o),
    .last_of_run_o   (last_of_run_o)
  );

endmodule

// File: dv/tb_fibre_hit_clusterizer.sv
// Self-checking testbench for fibre_hit_clusterizer: directed and random hit streams vs. a model.
module tb_fibre_hit_clusterizer;

  localparam int  NUM_FIBRES = 1024;
  localparam int  MAX_HITS   = 255;
  localparam int  TIME_BITS  = 24;
  localparam int  SETTLE_CYC = 60;
  localparam int  CYCLE_LIM  = 2000000;

  localparam int  FIBRE_W    = fhc_pkg::FIBRE_W;
  localparam int  CENTER_W   = fhc_pkg::CENTER_W;
  localparam int  COUNT_W    = fhc_pkg::COUNT_W;
  localparam int  GAP_W      = fhc_pkg::GAP_W;
  localparam int  CFG_W      = fhc_pkg::CFG_W;
  localparam int  IDX_W      = fhc_pkg::IDX_W;

  typedef struct {
    logic [CENTER_W-1:0]         center;
    logic signed [TIME_BITS-1:0] ctime;
    logic [COUNT_W-1:0]          count;
    logic                        known;
    logic                        ovf;
    logic                        run_end;
  } cluster_rec_t;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         cfg_we_i;
  logic [IDX_W-1:0]             cfg_idx_i;
  logic [CFG_W-1:0]             cfg_wdata_i;
  logic                         in_valid_i;
  logic                         in_ready_o;
  logic [FIBRE_W-1:0]           fibre_i;
  logic signed [TIME_BITS-1:0]  hit_time_i;
  logic                         last_hit_i;
  logic                         out_valid_o;
  logic                         out_ready_i;
  logic [CENTER_W-1:0]          center_fibre_o;
  logic signed [TIME_BITS-1:0]  cluster_time_o;
  logic [COUNT_W-1:0]           hit_count_o;
  logic                         size_known_o;
  logic                         size_overflow_o;
  logic                         last_of_run_o;

  fibre_hit_clusterizer #(
    .NUM_FIBRES (NUM_FIBRES),
    .MAX_HITS   (MAX_HITS),
    .TIME_BITS  (TIME_BITS)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .fibre_i         (fibre_i),
    .hit_time_i      (hit_time_i),
    .last_hit_i      (last_hit_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .center_fibre_o  (center_fibre_o),
    .cluster_time_o  (cluster_time_o),
    .hit_count_o     (hit_count_o),
    .size_known_o    (size_known_o),
    .size_overflow_o (size_overflow_o),
    .last_of_run_o   (last_of_run_o)
  );

  // model state
  logic             clus_en   = fhc_pkg::ENABLE_RST;
  logic [GAP_W-1:0] gap_lim   = fhc_pkg::GAP_RST;
  int               acc_fibre = 0;
  longint           acc_time  = 0;
  int               acc_hits  = 0;
  int               prev_fibre = 0;
  longint           prev_time = 0;
  bit               clus_open = 0;

  cluster_rec_t     pending_clusters[$];
  int               n_fail    = 0;
  int               cycle_cnt = 0;
  bit               idle_en   = 1;
  int               rdy_hold  = 0;

  always #5 clk_i = ~clk_i;

  function automatic cluster_rec_t close_cluster(logic ovf);
    cluster_rec_t r;
    longint       c;
    longint       ctr;
    c   = (acc_hits != 0) ? acc_hits : 1;
    ctr = (longint'(acc_fibre) * 256) / c;
    if (ctr > longint'(fhc_pkg::CENTER_MAX)) ctr = fhc_pkg::CENTER_MAX;
    r.center  = ctr[CENTER_W-1:0];
    r.ctime   = TIME_BITS'(acc_time / c); // truncates toward zero
    r.count   = (acc_hits > 255) ? fhc_pkg::COUNT_MAX : COUNT_W'(acc_hits);
    r.known   = 1'b1;
    r.ovf     = ovf;
    r.run_end = 1'b0;
    clus_open = 0;
    return r;
  endfunction

  function automatic void predict_hit(logic [FIBRE_W-1:0] f_in,
                                      logic signed [TIME_BITS-1:0] t_in, logic is_last);
    cluster_rec_t res[$];
    cluster_rec_t r;
    int           f;
    longint       t;
    longint       dt;
    f = f_in;
    if (f > NUM_FIBRES - 1) f = NUM_FIBRES - 1;
    t = t_in;
    if (clus_open) begin
      dt = t - prev_time;
      if (dt < 0) dt = -dt;
      if (!clus_en || (f - prev_fibre) > 1 || dt > longint'(gap_lim))
        res.insert(res.size(), close_cluster(1'b0));
    end
    if (clus_en) begin
      if (!clus_open) begin
        acc_fibre = 0;
        acc_time  = 0;
        acc_hits  = 0;
        clus_open = 1;
      end
      acc_fibre += f;
      acc_time  += t;
      acc_hits++;
      if (acc_hits >= MAX_HITS) res.insert(res.size(), close_cluster(1'b1));
      else if (is_last) res.insert(res.size(), close_cluster(1'b0));
    end else begin
      r.center  = CENTER_W'(f * 256);
      r.ctime   = t_in;
      r.count   = COUNT_W'(1);
      r.known   = 1'b0;
      r.ovf     = 1'b0;
      r.run_end = 1'b0;
      res.insert(res.size(), r);
    end
    prev_fibre = f;
    prev_time  = t;
    if (res.size() > 0) res[res.size()-1].run_end = 1'b1;
    foreach (res[i]) pending_clusters.insert(pending_clusters.size(), res[i]);
  endfunction

  function automatic void check_field(string name, logic signed [31:0] exp_v,
                                      logic signed [31:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      n_fail++;
    end
  endfunction

  function automatic void check_cluster();
    cluster_rec_t e;
    if (pending_clusters.size() == 0) begin
      $error("unexpected cluster: center_fibre %0d cluster_time %0d hit_count %0d",
             center_fibre_o, cluster_time_o, hit_count_o);
      n_fail++;
      return;
    end
    e = pending_clusters.pop_front();
    check_field("center_fibre", e.center, center_fibre_o);
    check_field("cluster_time", e.ctime, cluster_time_o);
    check_field("hit_count", e.count, hit_count_o);
    check_field("size_known", e.known, size_known_o);
    check_field("size_overflow", e.ovf, size_overflow_o);
    check_field("last_of_run", e.run_end, last_of_run_o);
  endfunction

  // config, then input beat, then output beat (the block itself applies a config write after a hit of that cycle)
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) begin
        if (cfg_idx_i == fhc_pkg::CFG_ENABLE) clus_en = cfg_wdata_i[0];
        else if (cfg_idx_i == fhc_pkg::CFG_GAP) gap_lim = cfg_wdata_i[GAP_W-1:0];
      end
      if (in_valid_i && in_ready_o) predict_hit(fibre_i, hit_time_i, last_hit_i);
      if (out_valid_o && out_ready_i) check_cluster();
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIM) begin
      $display("tb: failure");
      $finish;
    end
  end

  // receiver backpressure: random low bursts
  always @(negedge clk_i) begin
    if (!idle_en) begin
      out_ready_i <= 1'b1;
    end else if (rdy_hold > 0) begin
      rdy_hold = rdy_hold - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      out_ready_i <= 1'b0;
      rdy_hold = $urandom_range(0, 6);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  task automatic send_hit(logic [FIBRE_W-1:0] f, logic signed [TIME_BITS-1:0] t,
                          logic is_last);
    int gap;
    @(negedge clk_i);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 7);
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    fibre_i    <= f;
    hit_time_i <= t;
    last_hit_i <= is_last;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // drop valid, drain every expected cluster, then let the back end go quiet
  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_clusters.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic test_directed_clusters();
    send_hit(10'd0, 24'sd0, 1'b1);
    // gap exactly at the limit joins
    send_hit(10'd1023, 24'sd8388527, 1'b0);
    send_hit(10'd1023, 24'sd8388607, 1'b1);
    // one beyond the limit closes: two clusters from the second hit
    send_hit(10'd5, -24'sd8388608, 1'b0);
    send_hit(10'd6, -24'sd8388527, 1'b1);
    // fibre step of two closes
    send_hit(10'd10, 24'sd100, 1'b0);
    send_hit(10'd12, 24'sd100, 1'b1);
    // out of order fibres join; negative mean truncates toward zero
    send_hit(10'd20, -24'sd7, 1'b0);
    send_hit(10'd18, -24'sd3, 1'b0);
    send_hit(10'd19, -24'sd1, 1'b1);
    // fractional center floors
    send_hit(10'd100, 24'sd50, 1'b0);
    send_hit(10'd101, 24'sd52, 1'b0);
    send_hit(10'd101, 24'sd60, 1'b1);
    settle();
  endtask

  task automatic test_passthrough();
    send_hit(10'd300, 24'sd0, 1'b0);
    send_hit(10'd301, 24'sd5, 1'b0);
    settle();
    // cluster still open: next hit flushes it, then passes through
    write_reg(fhc_pkg::CFG_ENABLE, CFG_W'(0));
    send_hit(10'd302, 24'sd10, 1'b0);
    send_hit(10'd1023, -24'sd8388608, 1'b1);
    send_hit(10'd0, 24'sd8388607, 1'b0);
    settle();
    write_reg(fhc_pkg::CFG_ENABLE, CFG_W'(1));
  endtask

  task automatic test_gap_extremes();
    write_reg(fhc_pkg::CFG_GAP, CFG_W'(0));
    send_hit(10'd40, 24'sd100, 1'b0);
    send_hit(10'd41, 24'sd100, 1'b0);
    send_hit(10'd42, 24'sd101, 1'b1);
    settle();
    write_reg(fhc_pkg::CFG_GAP, 24'hFFFFFF);
    send_hit(10'd7, -24'sd8388608, 1'b0);
    send_hit(10'd8, 24'sd8388607, 1'b1);
    settle();
  endtask

  task automatic test_max_hits();
    write_reg(fhc_pkg::CFG_GAP, CFG_W'(0));
    // full cluster, last mark on the closing hit
    for (int k = 0; k < MAX_HITS; k++)
      send_hit(10'd1023, 24'sd8388607, k == MAX_HITS - 1);
    // full cluster, one more hit opens a fresh one
    for (int k = 0; k <= MAX_HITS; k++)
      send_hit((k % 2) ? 10'd1022 : 10'd1023, -24'sd8388608, k == MAX_HITS);
    settle();
  endtask

  task automatic run_random(int n_items);
    int                          sent;
    int                          len;
    int                          sel;
    int                          df;
    int                          tstep;
    bit                          drop_last;
    logic [FIBRE_W-1:0]          cur_f;
    logic signed [TIME_BITS-1:0] cur_t;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 4) == 0) begin
        send_hit(FIBRE_W'($urandom), TIME_BITS'($urandom), $urandom_range(0, 3) == 0);
        sent++;
      end else begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 48) : $urandom_range(1, 16);
        drop_last = ($urandom_range(0, 9) == 0);
        cur_f = FIBRE_W'($urandom);
        cur_t = TIME_BITS'($urandom);
        for (int k = 0; k < len; k++) begin
          send_hit(cur_f, cur_t, (k == len - 1) && !drop_last);
          sent++;
          sel = $urandom_range(0, 19);
          if (sel < 12) df = $urandom_range(0, 1);
          else if (sel < 15) df = $urandom_range(2, 5);
          else if (sel < 17) df = 0 - int'($urandom_range(1, 3));
          else df = $urandom_range(6, 1023);
          cur_f = FIBRE_W'(int'(cur_f) + df);
          if (gap_lim > 4000) tstep = $urandom_range(0, 4000);
          else tstep = $urandom_range(0, gap_lim + gap_lim / 4 + 2);
          if ($urandom_range(0, 9) == 0) tstep = -tstep;
          cur_t = TIME_BITS'(int'(cur_t) + tstep);
        end
      end
    end
  endtask

  task automatic run_phase(logic en, logic [GAP_W-1:0] gap, int n_items, bit idle);
    settle();
    write_reg(fhc_pkg::CFG_ENABLE, CFG_W'(en));
    write_reg(fhc_pkg::CFG_GAP, CFG_W'(gap));
    idle_en = idle;
    run_random(n_items);
  endtask

  task automatic test_random();
    run_phase(1'b1, 24'd80, 300, 1);
    run_phase(1'b1, 24'd0, 220, 1);
    run_phase(1'b1, 24'hFFFFFF, 180, 1);
    run_phase(1'b0, GAP_W'($urandom), 180, 1);
    run_phase(1'b1, GAP_W'($urandom_range(0, 2000)), 250, 1);
    run_phase(1'b1, 24'd80, 290, 0);
    settle();
  endtask

  initial begin
    clk_i       = 1'b0;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = fhc_pkg::CFG_ENABLE;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    fibre_i     = '0;
    hit_time_i  = '0;
    last_hit_i  = 1'b0;
    out_ready_i = 1'b0;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed_clusters();
    test_passthrough();
    test_gap_extremes();
    test_max_hits();
    test_random();

    if (n_fail == 0 && pending_clusters.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
